// ===== hdl/fla_pkg.sv =====
`default_nettype none

package fla_pkg;

	localparam int unsigned ADDR_BITS = 20;
	localparam int unsigned SIZE_BITS = 21;
	localparam int unsigned SUM_BITS  = 22;

	localparam logic [SIZE_BITS-1:0] REGION_CAP   = SIZE_BITS'(1 << ADDR_BITS);
	localparam logic [SIZE_BITS-1:0] REGION_RESET = 21'd1048576;
	localparam logic [SUM_BITS-1:0]  HDR_BYTES    = 22'd16;
	localparam logic [SUM_BITS-1:0]  ALIGN_MASK   = 22'd7;

	typedef logic [1:0] status_t;
	localparam status_t STAT_OK      = 2'd0;
	localparam status_t STAT_BADARG  = 2'd1;
	localparam status_t STAT_NOSPACE = 2'd2;
	localparam status_t STAT_BADPTR  = 2'd3;

	typedef logic [1:0] fit_t;
	localparam fit_t FIT_BEST  = 2'd0;
	localparam fit_t FIT_WORST = 2'd1;
	localparam fit_t FIT_FIRST = 2'd2;
	localparam fit_t FIT_BAD   = 2'd3;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// one table entry: header offset and payload bytes
	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [SIZE_BITS-1:0] bytes;
	} span_t;

endpackage

`default_nettype wire

// ===== hdl/fla_ram.sv =====
`default_nettype none

module fla_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IW    = 6
) (
	input  wire              clk,
	input  wire              we,
	input  wire [IW-1:0]     waddr,
	input  fla_pkg::span_t   wdata,
	input  wire [IW-1:0]     raddr,
	output fla_pkg::span_t   rdata
);

	fla_pkg::span_t mem [DEPTH];
	fla_pkg::span_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/free_list_block_allocator_unit.sv =====
`default_nettype none

// channel  | handshake           | word
// ---------+---------------------+-----------------------------------------------
// in       | in_valid/in_ready   | func, request_size, fit_style, free_offset
// out      | out_valid/out_ready | status, payload_offset, granted_bytes
// cfg      | cfg_valid/cfg_ready | region_bytes
//
// one word at a time; a sequencer shares one table read port and one add/compare path.
// allocate: one scan over both tables, then a shift down to close the gap when a
// whole extent is taken. free: a scan of the block table and one of the extent table,
// then a shift to insert an extent or to merge three extents.
// reset empties both tables; the first word forms the region in S_FORM before its check.
// in_ready is low until the result register is loaded; a result still waiting there stalls it.

module free_list_block_allocator_unit #(
	parameter int unsigned FREE_SLOTS  = 64,
	parameter int unsigned ALLOC_SLOTS = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         func,
	input  wire  [20:0] request_size,
	input  wire  [1:0]  fit_style,
	input  wire  [19:0] free_offset,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  status,
	output logic [19:0] payload_offset,
	output logic [20:0] granted_bytes,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [20:0] region_bytes
);

	localparam int unsigned SCAN_LEN = (FREE_SLOTS > ALLOC_SLOTS) ? FREE_SLOTS : ALLOC_SLOTS;
	localparam int unsigned FW = $clog2(FREE_SLOTS);
	localparam int unsigned AW = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;
	localparam int unsigned CW = $clog2(FREE_SLOTS + 1);
	localparam int unsigned KW = $clog2(SCAN_LEN + 1);
	localparam int unsigned AB = fla_pkg::ADDR_BITS;
	localparam int unsigned SB = fla_pkg::SIZE_BITS;
	localparam int unsigned XB = fla_pkg::SUM_BITS;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_FORM   = 9'b000000010,
		S_CHECK  = 9'b000000100,
		S_BSCAN  = 9'b000001000,
		S_ESCAN  = 9'b000010000,
		S_DECIDE = 9'b000100000,
		S_SHDN   = 9'b001000000,
		S_SHUP   = 9'b010000000,
		S_RESP   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [SB-1:0]          region_q;
	logic                   formed_q;
	logic [CW-1:0]          cnt_q;
	logic [ALLOC_SLOTS-1:0] valid_q;

	logic                   func_q;
	logic [XB-1:0]          need_q;
	fla_pkg::fit_t          style_q;
	logic [AB-1:0]          off_q;

	logic [KW-1:0]          k_q;
	logic                   rd_v_s1;
	logic [KW-1:0]          rd_idx_s1;
	logic [CW-1:0]          sh_q;

	logic                   found_q;
	logic [FW-1:0]          pick_q;
	fla_pkg::span_t         pick_d_q;
	logic                   slot_found_q;
	logic [AW-1:0]          slot_q;

	logic                   blk_found_q;
	logic [AW-1:0]          idx_q;
	logic [AB-1:0]          a_q;
	logic [SB-1:0]          s_q;
	logic [CW-1:0]          at_q;
	fla_pkg::span_t         prev_q;
	fla_pkg::span_t         next_q;
	logic                   next_seen_q;

	fla_pkg::status_t       res_status_q;
	logic [AB-1:0]          res_off_q;
	logic [SB-1:0]          res_bytes_q;
	logic                   out_valid_q;
	fla_pkg::status_t       out_status_q;
	logic [AB-1:0]          out_off_q;
	logic [SB-1:0]          out_bytes_q;

	logic                   ext_we;
	logic [FW-1:0]          ext_waddr;
	logic [FW-1:0]          ext_raddr;
	fla_pkg::span_t         ext_wdata;
	fla_pkg::span_t         ext_rdata;
	logic                   blk_we;
	fla_pkg::span_t         blk_wdata;
	fla_pkg::span_t         blk_rdata;

	fla_ram #(.DEPTH(FREE_SLOTS), .IW(FW)) u_ext (
		.clk   (clk),
		.we    (ext_we),
		.waddr (ext_waddr),
		.wdata (ext_wdata),
		.raddr (ext_raddr),
		.rdata (ext_rdata)
	);

	fla_ram #(.DEPTH(ALLOC_SLOTS), .IW(AW)) u_blk (
		.clk   (clk),
		.we    (blk_we),
		.waddr (slot_q),
		.wdata (blk_wdata),
		.raddr (k_q[AW-1:0]),
		.rdata (blk_rdata)
	);

	// shared arithmetic
	logic [SB-1:0] total;
	logic [XB-1:0] need_in;
	logic [XB-1:0] rem;
	logic          take_all;
	logic [XB-1:0] prev_end;
	logic [XB-1:0] blk_end;
	logic          mprev;
	logic          mnext;
	logic          table_full;
	logic [CW-1:0] sh_dec;
	logic [KW-1:0] scan_limit;
	logic          blk_hit;
	logic          fits;
	logic          better;

	assign total      = (region_q > fla_pkg::REGION_CAP) ? fla_pkg::REGION_CAP : region_q;
	assign need_in    = (XB'(request_size) + fla_pkg::ALIGN_MASK) & ~fla_pkg::ALIGN_MASK;
	assign rem        = XB'(pick_d_q.bytes) - need_q;
	assign take_all   = rem <= fla_pkg::HDR_BYTES;
	assign prev_end   = XB'(prev_q.start) + fla_pkg::HDR_BYTES + XB'(prev_q.bytes);
	assign blk_end    = XB'(a_q) + fla_pkg::HDR_BYTES + XB'(s_q);
	assign mprev      = (at_q != '0) && (prev_end == XB'(a_q));
	assign mnext      = (at_q < cnt_q) && (blk_end == XB'(next_q.start));
	assign table_full = cnt_q >= CW'(FREE_SLOTS);
	assign sh_dec     = sh_q - 1'b1;
	assign scan_limit = (func_q == fla_pkg::FUNC_FREE) ? KW'(cnt_q) : KW'(SCAN_LEN);
	assign blk_hit    = rd_v_s1 && !blk_found_q && valid_q[rd_idx_s1[AW-1:0]] &&
	                    (XB'(blk_rdata.start) + fla_pkg::HDR_BYTES == XB'(off_q));
	assign fits       = XB'(ext_rdata.bytes) >= need_q;
	assign better     = !found_q ||
	                    (style_q == fla_pkg::FIT_BEST  && ext_rdata.bytes < pick_d_q.bytes) ||
	                    (style_q == fla_pkg::FIT_WORST && ext_rdata.bytes > pick_d_q.bytes);

	always_comb begin
		ext_we    = 1'b0;
		ext_waddr = '0;
		ext_wdata = '0;
		ext_raddr = '0;
		blk_we    = 1'b0;
		blk_wdata = '0;
		unique case (state_q)
			S_FORM: begin
				if (XB'(total) > fla_pkg::HDR_BYTES) begin
					ext_we          = 1'b1;
					ext_wdata.start = '0;
					ext_wdata.bytes = total - SB'(fla_pkg::HDR_BYTES);
				end
			end
			S_ESCAN: begin
				ext_raddr = k_q[FW-1:0];
			end
			S_DECIDE: begin
				if (func_q == fla_pkg::FUNC_ALLOC) begin
					if (found_q && slot_found_q) begin
						blk_we          = 1'b1;
						blk_wdata.start = pick_d_q.start;
						blk_wdata.bytes = take_all ? pick_d_q.bytes : SB'(need_q);
						if (!take_all) begin
							ext_we          = 1'b1;
							ext_waddr       = pick_q;
							ext_wdata.start = AB'(XB'(pick_d_q.start) + fla_pkg::HDR_BYTES + need_q);
							ext_wdata.bytes = SB'(rem - fla_pkg::HDR_BYTES);
						end
					end
				end else begin
					if (mprev && mnext) begin
						ext_we          = 1'b1;
						ext_waddr       = FW'(at_q - 1'b1);
						ext_wdata.start = prev_q.start;
						ext_wdata.bytes = SB'(XB'(prev_q.bytes) + fla_pkg::HDR_BYTES + XB'(s_q) +
						                  fla_pkg::HDR_BYTES + XB'(next_q.bytes));
					end else if (mprev) begin
						ext_we          = 1'b1;
						ext_waddr       = FW'(at_q - 1'b1);
						ext_wdata.start = prev_q.start;
						ext_wdata.bytes = SB'(XB'(prev_q.bytes) + XB'(s_q) + fla_pkg::HDR_BYTES);
					end else if (mnext) begin
						ext_we          = 1'b1;
						ext_waddr       = FW'(at_q);
						ext_wdata.start = a_q;
						ext_wdata.bytes = SB'(XB'(s_q) + fla_pkg::HDR_BYTES + XB'(next_q.bytes));
					end
				end
			end
			S_SHDN: begin
				ext_raddr = sh_q[FW-1:0];
				if (rd_v_s1) begin
					ext_we    = 1'b1;
					ext_waddr = FW'(rd_idx_s1 - 1'b1);
					ext_wdata = ext_rdata;
				end
			end
			S_SHUP: begin
				ext_raddr = sh_dec[FW-1:0];
				if (rd_v_s1) begin
					ext_we    = 1'b1;
					ext_waddr = rd_idx_s1[FW-1:0];
					ext_wdata = ext_rdata;
				end else if (sh_q <= at_q) begin
					ext_we          = 1'b1;
					ext_waddr       = FW'(at_q);
					ext_wdata.start = a_q;
					ext_wdata.bytes = s_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			region_q    <= fla_pkg::REGION_RESET;
			formed_q    <= 1'b0;
			cnt_q       <= '0;
			valid_q     <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				region_q <= region_bytes;
			end
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						need_q  <= need_in;
						style_q <= fit_style;
						off_q   <= free_offset;
						state_q <= formed_q ? S_CHECK : S_FORM;
					end
				end
				S_FORM: begin
					cnt_q    <= (XB'(total) > fla_pkg::HDR_BYTES) ? CW'(1) : '0;
					formed_q <= 1'b1;
					state_q  <= S_CHECK;
				end
				S_CHECK: begin
					k_q          <= '0;
					rd_v_s1      <= 1'b0;
					found_q      <= 1'b0;
					slot_found_q <= 1'b0;
					blk_found_q  <= 1'b0;
					at_q         <= '0;
					next_seen_q  <= 1'b0;
					res_off_q    <= '0;
					res_bytes_q  <= '0;
					if (func_q == fla_pkg::FUNC_ALLOC) begin
						if (need_q == '0 || style_q == fla_pkg::FIT_BAD) begin
							res_status_q <= fla_pkg::STAT_BADARG;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_ESCAN;
						end
					end else begin
						if (off_q == '0) begin
							res_status_q <= fla_pkg::STAT_OK;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_BSCAN;
						end
					end
				end
				S_BSCAN: begin
					if (k_q < KW'(ALLOC_SLOTS) && !blk_found_q) begin
						rd_v_s1   <= 1'b1;
						rd_idx_s1 <= k_q;
						k_q       <= k_q + 1'b1;
					end else begin
						rd_v_s1 <= 1'b0;
					end
					if (blk_hit) begin
						blk_found_q <= 1'b1;
						idx_q       <= rd_idx_s1[AW-1:0];
						a_q         <= blk_rdata.start;
						s_q         <= blk_rdata.bytes;
					end
					if (blk_found_q) begin
						k_q     <= '0;
						state_q <= S_ESCAN;
					end else if (k_q >= KW'(ALLOC_SLOTS) && !rd_v_s1) begin
						res_status_q <= fla_pkg::STAT_BADPTR;
						state_q      <= S_RESP;
					end
				end
				S_ESCAN: begin
					if (k_q < scan_limit) begin
						rd_v_s1   <= k_q < KW'(cnt_q);
						rd_idx_s1 <= k_q;
						k_q       <= k_q + 1'b1;
						if (func_q == fla_pkg::FUNC_ALLOC && k_q < KW'(ALLOC_SLOTS) &&
						    !slot_found_q && !valid_q[k_q[AW-1:0]]) begin
							slot_found_q <= 1'b1;
							slot_q       <= k_q[AW-1:0];
						end
					end else begin
						rd_v_s1 <= 1'b0;
					end
					if (rd_v_s1) begin
						if (func_q == fla_pkg::FUNC_ALLOC) begin
							if (fits && better) begin
								found_q  <= 1'b1;
								pick_q   <= rd_idx_s1[FW-1:0];
								pick_d_q <= ext_rdata;
							end
						end else if (ext_rdata.start < a_q) begin
							prev_q <= ext_rdata;
							at_q   <= CW'(rd_idx_s1) + 1'b1;
						end else if (!next_seen_q) begin
							next_q      <= ext_rdata;
							next_seen_q <= 1'b1;
						end
					end
					if (k_q >= scan_limit && !rd_v_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					rd_v_s1 <= 1'b0;
					if (func_q == fla_pkg::FUNC_ALLOC) begin
						if (!(found_q && slot_found_q)) begin
							res_status_q <= fla_pkg::STAT_NOSPACE;
							state_q      <= S_RESP;
						end else begin
							valid_q[slot_q] <= 1'b1;
							res_status_q    <= fla_pkg::STAT_OK;
							res_off_q       <= AB'(XB'(pick_d_q.start) + fla_pkg::HDR_BYTES);
							res_bytes_q     <= take_all ? pick_d_q.bytes : SB'(need_q);
							if (take_all) begin
								sh_q    <= CW'(pick_q) + 1'b1;
								state_q <= S_SHDN;
							end else begin
								state_q <= S_RESP;
							end
						end
					end else begin
						if (!mprev && !mnext && table_full) begin
							res_status_q <= fla_pkg::STAT_NOSPACE;
							state_q      <= S_RESP;
						end else begin
							valid_q[idx_q] <= 1'b0;
							res_status_q   <= fla_pkg::STAT_OK;
							if (mprev && mnext) begin
								sh_q    <= at_q + 1'b1;
								state_q <= S_SHDN;
							end else if (!mprev && !mnext) begin
								sh_q    <= cnt_q;
								state_q <= S_SHUP;
							end else begin
								state_q <= S_RESP;
							end
						end
					end
				end
				S_SHDN: begin
					// close the gap: entry j moves to j-1
					if (sh_q < cnt_q) begin
						rd_v_s1   <= 1'b1;
						rd_idx_s1 <= KW'(sh_q);
						sh_q      <= sh_q + 1'b1;
					end else begin
						rd_v_s1 <= 1'b0;
						if (!rd_v_s1) begin
							cnt_q   <= cnt_q - 1'b1;
							state_q <= S_RESP;
						end
					end
				end
				S_SHUP: begin
					// open a gap at the insert point, top entry first
					if (sh_q > at_q) begin
						rd_v_s1   <= 1'b1;
						rd_idx_s1 <= KW'(sh_q);
						sh_q      <= sh_dec;
					end else begin
						rd_v_s1 <= 1'b0;
						if (!rd_v_s1) begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_RESP;
						end
					end
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_off_q    <= res_off_q;
						out_bytes_q  <= res_bytes_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready       = state_q == S_IDLE;
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign payload_offset = out_off_q;
	assign granted_bytes  = out_bytes_q;

endmodule

`default_nettype wire

// ===== verif/free_list_block_allocator_unit_tb.sv =====
`default_nettype none

module free_list_block_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS      = 64;
	localparam int DRAIN_WAIT = 300;
	localparam int LIMIT      = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = fla_pkg::FUNC_ALLOC;
	logic [20:0] request_size = '0;
	logic [1:0]  fit_style = fla_pkg::FIT_BEST;
	logic [19:0] free_offset = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [19:0] payload_offset;
	logic [20:0] granted_bytes;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [20:0] region_bytes = fla_pkg::REGION_RESET;

	free_list_block_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.request_size(request_size), .fit_style(fit_style), .free_offset(free_offset),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.payload_offset(payload_offset), .granted_bytes(granted_bytes),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .region_bytes(region_bytes)
	);

	always #2 clk = ~clk;

	typedef struct {
		fla_pkg::status_t st;
		logic [19:0]      off;
		logic [20:0]      bytes;
	} grant_t;

	grant_t grant_q[$];
	int     errors = 0;
	int     cycles = 0;

	// allocator shadow state
	longint unsigned ext_start[SLOTS];
	longint unsigned ext_bytes[SLOTS];
	int              ext_count = 0;
	longint unsigned blk_start[SLOTS];
	longint unsigned blk_bytes[SLOTS];
	bit              blk_live[SLOTS];
	bit              formed = 1'b0;
	longint unsigned region_cfg = fla_pkg::REGION_RESET;
	logic [19:0]     live_offs[$];

	function automatic grant_t mk(fla_pkg::status_t st, longint unsigned off,
			longint unsigned b);
		grant_t g;
		g.st = st;
		g.off = off[19:0];
		g.bytes = b[20:0];
		return g;
	endfunction

	function automatic grant_t allocate(longint unsigned req, fla_pkg::fit_t fit);
		int pick = 0;
		int slot = 0;
		bit found = 0;
		bit have_slot = 0;
		longint unsigned need, space, a;
		if (req == 0 || fit == fla_pkg::FIT_BAD)
			return mk(fla_pkg::STAT_BADARG, 0, 0);
		need = (req + 7) & ~64'd7;
		for (int i = 0; i < ext_count; i++) begin
			if (ext_bytes[i] < need)
				continue;
			if (!found || (fit == fla_pkg::FIT_BEST && ext_bytes[i] < ext_bytes[pick]) ||
					(fit == fla_pkg::FIT_WORST && ext_bytes[i] > ext_bytes[pick])) begin
				pick = i;
				found = 1;
				if (fit == fla_pkg::FIT_FIRST)
					break;
			end
		end
		for (int i = 0; i < SLOTS; i++)
			if (!blk_live[i]) begin
				slot = i;
				have_slot = 1;
				break;
			end
		if (!found || !have_slot)
			return mk(fla_pkg::STAT_NOSPACE, 0, 0);
		a = ext_start[pick];
		space = ext_bytes[pick];
		if (space - need <= 16) begin
			need = space;
			for (int i = pick; i + 1 < ext_count; i++) begin
				ext_start[i] = ext_start[i+1];
				ext_bytes[i] = ext_bytes[i+1];
			end
			ext_count--;
		end else begin
			ext_start[pick] = a + 16 + need;
			ext_bytes[pick] = space - need - 16;
		end
		blk_start[slot] = a;
		blk_bytes[slot] = need;
		blk_live[slot] = 1;
		return mk(fla_pkg::STAT_OK, a + 16, need);
	endfunction

	function automatic grant_t release_block(longint unsigned off);
		int idx = 0;
		int at = 0;
		bit found = 0;
		bit join_lo, join_hi;
		longint unsigned a, s;
		if (off == 0)
			return mk(fla_pkg::STAT_OK, 0, 0);
		for (int i = 0; i < SLOTS; i++)
			if (blk_live[i] && blk_start[i] + 16 == off) begin
				idx = i;
				found = 1;
				break;
			end
		if (!found)
			return mk(fla_pkg::STAT_BADPTR, 0, 0);
		a = blk_start[idx];
		s = blk_bytes[idx];
		while (at < ext_count && ext_start[at] < a)
			at++;
		join_lo = at > 0 && ext_start[at-1] + 16 + ext_bytes[at-1] == a;
		join_hi = at < ext_count && a + 16 + s == ext_start[at];
		if (!join_lo && !join_hi && ext_count >= SLOTS)
			return mk(fla_pkg::STAT_NOSPACE, 0, 0);
		blk_live[idx] = 0;
		if (join_lo && join_hi) begin
			ext_bytes[at-1] += 32 + s + ext_bytes[at];
			for (int i = at; i + 1 < ext_count; i++) begin
				ext_start[i] = ext_start[i+1];
				ext_bytes[i] = ext_bytes[i+1];
			end
			ext_count--;
		end else if (join_lo) begin
			ext_bytes[at-1] += s + 16;
		end else if (join_hi) begin
			ext_bytes[at] = s + 16 + ext_bytes[at];
			ext_start[at] = a;
		end else begin
			for (int i = ext_count; i > at; i--) begin
				ext_start[i] = ext_start[i-1];
				ext_bytes[i] = ext_bytes[i-1];
			end
			ext_start[at] = a;
			ext_bytes[at] = s;
			ext_count++;
		end
		return mk(fla_pkg::STAT_OK, 0, 0);
	endfunction

	function automatic grant_t predict_grant(logic f, logic [20:0] req, fla_pkg::fit_t fit,
			logic [19:0] off);
		grant_t g;
		longint unsigned total;
		longint unsigned cap;
		if (!formed) begin
			cap = 64'd1 << fla_pkg::ADDR_BITS;
			total = region_cfg > cap ? cap : region_cfg;
			ext_count = 0;
			if (total > 16) begin
				ext_start[0] = 0;
				ext_bytes[0] = total - 16;
				ext_count = 1;
			end
			formed = 1;
		end
		if (f == fla_pkg::FUNC_ALLOC) begin
			g = allocate(req, fit);
			if (g.st == fla_pkg::STAT_OK)
				live_offs.push_back(g.off);
		end else begin
			g = release_block(off);
			if (g.st == fla_pkg::STAT_OK && off != 0)
				foreach (live_offs[i])
					if (live_offs[i] == off) begin
						live_offs.delete(i);
						break;
					end
		end
		return g;
	endfunction

	task automatic send_word(logic f, logic [20:0] req, fla_pkg::fit_t fit, logic [19:0] off,
			bit typed, grant_t want);
		grant_t g;
		in_valid <= 1'b1;
		func <= f;
		request_size <= req;
		fit_style <= fit;
		free_offset <= off;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		g = predict_grant(f, req, fit, off);
		grant_q.push_back(typed ? want : g);
	endtask

	task automatic idle_cycles(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic write_region(logic [20:0] v);
		cfg_valid <= 1'b1;
		region_bytes <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (!formed)
			region_cfg = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (grant_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic random_words(int n);
		int burst = 0;
		int r;
		logic [20:0] req;
		logic [19:0] off;
		fla_pkg::fit_t fit;
		for (int k = 0; k < n; k++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				if ($urandom_range(0, 2) != 0)
					idle_cycles($urandom_range(1, 10));
			end
			burst--;
			r = $urandom_range(0, 99);
			fit = $urandom_range(0, 9) == 0 ? fla_pkg::FIT_BAD :
				fla_pkg::fit_t'($urandom_range(0, 2));
			if (r < 55 || live_offs.size() == 0) begin
				r = $urandom_range(0, 99);
				if (r < 75)
					req = 21'($urandom_range(1, 48));
				else if (r < 92)
					req = 21'($urandom_range(1, 600));
				else if (r < 97)
					req = 21'($urandom);
				else
					req = '0;
				send_word(fla_pkg::FUNC_ALLOC, req, fit, 20'($urandom), 0,
					mk(fla_pkg::STAT_OK, 0, 0));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 80)
					off = live_offs[$urandom_range(0, live_offs.size() - 1)];
				else if (r < 90)
					off = 20'($urandom);
				else if (r < 95)
					off = '0;
				else
					off = live_offs[0] + 20'd8;
				send_word(fla_pkg::FUNC_FREE, 21'($urandom), fla_pkg::fit_t'($urandom), off, 0,
					mk(fla_pkg::STAT_OK, 0, 0));
			end
		end
	endtask

	typedef struct {
		logic          f;
		logic [20:0]   req;
		fla_pkg::fit_t fit;
		logic [19:0]   off;
		bit            from_live;
		bit            typed;
		grant_t        want;
	} row_t;

	row_t rows[] = '{
		'{fla_pkg::FUNC_ALLOC, 21'd0, fla_pkg::FIT_BEST, 20'd0, 0, 1,
			'{fla_pkg::STAT_BADARG, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_ALLOC, 21'd8, fla_pkg::FIT_BAD, 20'd0, 0, 1,
			'{fla_pkg::STAT_BADARG, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_FREE, 21'd0, fla_pkg::FIT_BEST, 20'd0, 0, 1,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_FREE, 21'd0, fla_pkg::FIT_BEST, 20'hFFFFF, 0, 1,
			'{fla_pkg::STAT_BADPTR, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_ALLOC, 21'd1, fla_pkg::FIT_BEST, 20'd0, 0, 1,
			'{fla_pkg::STAT_OK, 20'd16, 21'd8}},
		'{fla_pkg::FUNC_ALLOC, 21'd1048576, fla_pkg::FIT_FIRST, 20'd0, 0, 1,
			'{fla_pkg::STAT_NOSPACE, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_ALLOC, 21'h1FFFFF, fla_pkg::FIT_WORST, 20'd0, 0, 1,
			'{fla_pkg::STAT_NOSPACE, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_ALLOC, 21'd100, fla_pkg::FIT_WORST, 20'd0, 0, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_ALLOC, 21'd24, fla_pkg::FIT_FIRST, 20'd0, 0, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_ALLOC, 21'd9, fla_pkg::FIT_BEST, 20'd0, 0, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_FREE, 21'd0, fla_pkg::FIT_BEST, 20'd0, 1, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_ALLOC, 21'd40, fla_pkg::FIT_BEST, 20'd0, 0, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_ALLOC, 21'd16, fla_pkg::FIT_WORST, 20'd0, 0, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_ALLOC, 21'd3700, fla_pkg::FIT_FIRST, 20'd0, 0, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_ALLOC, 21'd8, fla_pkg::FIT_BEST, 20'd0, 0, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_FREE, 21'd0, fla_pkg::FIT_BEST, 20'd0, 1, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_FREE, 21'd0, fla_pkg::FIT_BEST, 20'd0, 1, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_FREE, 21'd0, fla_pkg::FIT_BEST, 20'd0, 1, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_ALLOC, 21'd3000, fla_pkg::FIT_FIRST, 20'd0, 0, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_FREE, 21'd0, fla_pkg::FIT_BEST, 20'd0, 1, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}},
		'{fla_pkg::FUNC_FREE, 21'd0, fla_pkg::FIT_BEST, 20'd0, 1, 0,
			'{fla_pkg::STAT_OK, 20'd0, 21'd0}}
	};

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("word %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		grant_t w;
		if (out_valid && out_ready) begin
			if (grant_q.size() == 0) begin
				report("unexpected", status, 0);
			end else begin
				w = grant_q.pop_front();
				if (status !== w.st)
					report("status", status, w.st);
				if (payload_offset !== w.off)
					report("payload_offset", payload_offset, w.off);
				if (granted_bytes !== w.bytes)
					report("granted_bytes", granted_bytes, w.bytes);
			end
		end
	end

	// receiver: stall pattern rotates through four modes, one long hold-off
	always @(posedge clk) begin
		int mode;
		mode = (cycles / 256) % 4;
		if (cycles >= 20000 && cycles < 20600)
			out_ready <= 1'b0;
		else if (mode == 0)
			out_ready <= 1'b1;
		else if (mode == 1)
			out_ready <= $urandom_range(0, 1);
		else if (mode == 2)
			out_ready <= $urandom_range(0, 3) == 0;
		else
			out_ready <= (cycles % 7) < 3;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("free_list_block_allocator_unit: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_region(21'd4096);
		foreach (rows[i]) begin
			send_word(rows[i].f, rows[i].req, rows[i].fit,
				rows[i].from_live && live_offs.size() != 0 ? live_offs[0] : rows[i].off,
				rows[i].typed, rows[i].want);
			if (i % 5 == 4)
				idle_cycles($urandom_range(1, 6));
		end
		random_words(300);
		settle();
		// region is formed now, so later writes must leave the layout alone
		write_region(21'd24);
		random_words(150);
		settle();
		write_region(21'h1FFFFF);
		write_region(fla_pkg::REGION_RESET);
		random_words(150);
		settle();
		if (errors == 0)
			$display("free_list_block_allocator_unit: match");
		else
			$display("free_list_block_allocator_unit: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
